// ===== src/bis_pkg.sv =====
`timescale 1ns / 1ps

package bis_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 256;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned DIM_W      = 13;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CMDQ_DEPTH = 4;
    localparam int unsigned RES_DEPTH  = 4;
    localparam int unsigned PEND_W     = 3;

    localparam logic [15:0] RST_SCALE  = 16'd256;
    localparam logic [8:0]  RST_DIM    = 9'd256;
    localparam logic [7:0]  WEIGHT_ONE = 8'hFF;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCALE_X    = 3'd0,
        REG_SCALE_Y    = 3'd1,
        REG_IN_WIDTH   = 3'd2,
        REG_IN_HEIGHT  = 3'd3,
        REG_OUT_WIDTH  = 3'd4,
        REG_OUT_HEIGHT = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FLAG   = 2'd2
    } cmd_kind_t;

    typedef enum logic {
        BK_FIRST  = 1'b0,
        BK_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [8:0]  in_width;
        logic [8:0]  in_height;
        logic [8:0]  out_width;
        logic [8:0]  out_height;
    } cfg_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  fx;
        logic [7:0]  fy;
        logic [7:0]  pixel;
    } cmd_info_t;

    typedef struct packed {
        logic        out_of_range;
        logic [7:0]  pixel_out;
    } res_t;

endpackage

// ===== src/bis_ram.sv =====
`timescale 1ns / 1ps

module bis_ram #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 256,
    localparam int unsigned AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ===== src/bis_fifo.sv =====
`timescale 1ns / 1ps

module bis_fifo #(
    parameter  int unsigned WIDTH = 8,
    parameter  int unsigned DEPTH = 4,
    localparam int unsigned PW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != (PW + 1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // depth is a power of two, pointers wrap on their own
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== src/bis_front.sv =====
`timescale 1ns / 1ps

module bis_front #(
    parameter  int unsigned MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
    parameter  int unsigned MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
    localparam int unsigned AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bis_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  mode,
    input  logic [7:0]            src_row,
    input  logic [7:0]            src_col,
    input  logic [7:0]            src_pixel,
    input  logic [7:0]            out_row,
    input  logic [7:0]            out_col,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output bis_pkg::cmd_info_t    cmd_info,
    output logic [3:0][AW-1:0]    cmd_addr
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned RW = $clog2(MAX_HEIGHT);
    localparam int unsigned DW = bis_pkg::DIM_W;

    // stage 1: products
    logic        s1_valid_reg, s1_valid_next;
    logic        s1_load_reg;
    logic        s1_pos_oor_reg;
    logic [23:0] s1_x_reg;
    logic [23:0] s1_y_reg;
    logic [7:0]  s1_row_reg;
    logic [7:0]  s1_col_reg;
    logic [7:0]  s1_pixel_reg;

    // stage 2: neighbour coordinates
    logic                s2_valid_reg, s2_valid_next;
    bis_pkg::cmd_kind_t  s2_kind_reg, s2_kind_next;
    logic [RW-1:0]       s2_row0_reg, s2_row0_next;
    logic [RW-1:0]       s2_row1_reg, s2_row1_next;
    logic [CW-1:0]       s2_col0_reg, s2_col0_next;
    logic [CW-1:0]       s2_col1_reg, s2_col1_next;
    logic [7:0]          s2_fx_reg;
    logic [7:0]          s2_fy_reg;
    logic [7:0]          s2_pixel_reg;

    logic              accept;
    logic              in_store;
    logic              s1_move;
    logic              s2_move;
    logic [DW-1:0]     w_eff;
    logic [DW-1:0]     h_eff;
    logic [15:0]       nx;
    logic [15:0]       ny;
    logic [16:0]       nx_inc;
    logic [16:0]       ny_inc;
    logic [16:0]       nx1;
    logic [16:0]       ny1;
    logic              map_oor;

    function automatic logic [AW-1:0] store_addr(input logic [RW-1:0] row,
                                                 input logic [CW-1:0] col);
        store_addr = AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));
    endfunction

    assign s2_move  = !s2_valid_reg || cmd_ready;
    assign s1_move  = !s1_valid_reg || s2_move;
    assign in_ready = s1_move;
    assign accept   = in_valid && in_ready;

    assign in_store = (DW'(src_row) < DW'(MAX_HEIGHT)) && (DW'(src_col) < DW'(MAX_WIDTH));

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_move)
        begin
            s1_valid_next = accept && (mode || in_store);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_load_reg    <= !mode;
            s1_pos_oor_reg <= ({1'b0, out_col} >= cfg.out_width) ||
                              ({1'b0, out_row} >= cfg.out_height);
            s1_x_reg       <= 24'(out_col) * 24'(cfg.scale_x);
            s1_y_reg       <= 24'(out_row) * 24'(cfg.scale_y);
            s1_row_reg     <= src_row;
            s1_col_reg     <= src_col;
            s1_pixel_reg   <= src_pixel;
        end
    end

    // source size clipped to the store
    assign w_eff = (DW'(cfg.in_width) < DW'(MAX_WIDTH)) ? DW'(cfg.in_width) : DW'(MAX_WIDTH);
    assign h_eff = (DW'(cfg.in_height) < DW'(MAX_HEIGHT)) ? DW'(cfg.in_height)
                                                          : DW'(MAX_HEIGHT);

    assign nx      = s1_x_reg[23:8];
    assign ny      = s1_y_reg[23:8];
    assign nx_inc  = 17'(nx) + 17'd1;
    assign ny_inc  = 17'(ny) + 17'd1;
    assign nx1     = (nx_inc < 17'(w_eff)) ? nx_inc : 17'(w_eff) - 17'd1;
    assign ny1     = (ny_inc < 17'(h_eff)) ? ny_inc : 17'(h_eff) - 17'd1;
    assign map_oor = (nx >= 16'(w_eff)) || (ny >= 16'(h_eff));

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (s2_move)
        begin
            s2_valid_next = s1_valid_reg;
        end
        if (s1_load_reg)
        begin
            s2_kind_next = bis_pkg::CMD_LOAD;
            s2_row0_next = RW'(s1_row_reg);
            s2_col0_next = CW'(s1_col_reg);
        end
        else
        begin
            s2_kind_next = (s1_pos_oor_reg || map_oor) ? bis_pkg::CMD_FLAG : bis_pkg::CMD_SAMPLE;
            s2_row0_next = RW'(ny);
            s2_col0_next = CW'(nx);
        end
        s2_row1_next = RW'(ny1);
        s2_col1_next = CW'(nx1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move && s1_valid_reg)
        begin
            s2_kind_reg  <= s2_kind_next;
            s2_row0_reg  <= s2_row0_next;
            s2_row1_reg  <= s2_row1_next;
            s2_col0_reg  <= s2_col0_next;
            s2_col1_reg  <= s2_col1_next;
            s2_fx_reg    <= s1_x_reg[7:0];
            s2_fy_reg    <= s1_y_reg[7:0];
            s2_pixel_reg <= s1_pixel_reg;
        end
    end

    assign cmd_valid      = s2_valid_reg;
    assign cmd_info.kind  = s2_kind_reg;
    assign cmd_info.fx    = s2_fx_reg;
    assign cmd_info.fy    = s2_fy_reg;
    assign cmd_info.pixel = s2_pixel_reg;
    assign cmd_addr[0]    = store_addr(s2_row0_reg, s2_col0_reg);
    assign cmd_addr[1]    = store_addr(s2_row0_reg, s2_col1_reg);
    assign cmd_addr[2]    = store_addr(s2_row1_reg, s2_col0_reg);
    assign cmd_addr[3]    = store_addr(s2_row1_reg, s2_col1_reg);

endmodule

// ===== src/bis_back.sv =====
`timescale 1ns / 1ps

module bis_back #(
    parameter int unsigned AW = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  bis_pkg::cmd_info_t    cmd_info,
    input  logic [3:0][AW-1:0]    cmd_addr,
    output logic                  ram_we,
    output logic [AW-1:0]         ram_waddr,
    output logic [7:0]            ram_wdata,
    output logic [AW-1:0]         ram_raddr_a,
    output logic [AW-1:0]         ram_raddr_b,
    input  logic [7:0]            ram_rdata_a,
    input  logic [7:0]            ram_rdata_b,
    output logic                  res_valid,
    output bis_pkg::res_t         res,
    input  logic                  res_taken
);

    localparam int unsigned PW = bis_pkg::PEND_W;

    bis_pkg::back_state_t state_reg, state_next;

    logic [PW-1:0] pend_reg, pend_next;
    logic          credit;
    logic          issue;

    logic          e1_valid_reg;
    logic          e1_oor_reg;
    logic [7:0]    e1_fx_reg;
    logic [7:0]    e1_fy_reg;

    logic          e2_valid_reg;
    logic          e2_oor_reg;
    logic [7:0]    e2_fx_reg;
    logic [7:0]    e2_fy_reg;
    logic [15:0]   e2_h0_reg;

    logic          e3_valid_reg;
    logic          e3_oor_reg;
    logic [7:0]    e3_fy_reg;
    logic [15:0]   e3_h1_reg;
    logic [23:0]   e3_v0_reg;

    logic [7:0]    e1_x1;
    logic [7:0]    e2_x1;
    logic [7:0]    e2_y1;
    logic [15:0]   h0_next;
    logic [15:0]   h1_next;
    logic [23:0]   v0_next;
    logic [23:0]   v1;
    logic [23:0]   acc;

    assign credit = (pend_reg < PW'(bis_pkg::RES_DEPTH));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bis_pkg::BK_FIRST:
            begin
                if (cmd_valid && (cmd_info.kind == bis_pkg::CMD_SAMPLE) && credit)
                begin
                    state_next = bis_pkg::BK_SECOND;
                end
            end
            bis_pkg::BK_SECOND:
            begin
                state_next = bis_pkg::BK_FIRST;
            end
            default:
            begin
                state_next = bis_pkg::BK_FIRST;
            end
        endcase
    end

    always_comb
    begin
        cmd_ready   = 1'b0;
        issue       = 1'b0;
        ram_we      = 1'b0;
        ram_raddr_a = cmd_addr[0];
        ram_raddr_b = cmd_addr[1];
        unique case (state_reg)
            bis_pkg::BK_FIRST:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd_info.kind)
                        bis_pkg::CMD_LOAD:
                        begin
                            ram_we    = 1'b1;
                            cmd_ready = 1'b1;
                        end
                        bis_pkg::CMD_FLAG:
                        begin
                            issue     = credit;
                            cmd_ready = credit;
                        end
                        bis_pkg::CMD_SAMPLE:
                        begin
                            issue = credit;
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase
                end
            end
            bis_pkg::BK_SECOND:
            begin
                ram_raddr_a = cmd_addr[2];
                ram_raddr_b = cmd_addr[3];
                cmd_ready   = 1'b1;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    assign ram_waddr = cmd_addr[0];
    assign ram_wdata = cmd_info.pixel;

    assign pend_next = pend_reg + PW'(issue) - PW'(res_taken);

    // top pair arrives in e1, bottom pair in e2
    assign e1_x1   = bis_pkg::WEIGHT_ONE - e1_fx_reg;
    assign e2_x1   = bis_pkg::WEIGHT_ONE - e2_fx_reg;
    assign e2_y1   = bis_pkg::WEIGHT_ONE - e2_fy_reg;
    assign h0_next = 16'(16'(ram_rdata_a) * 16'(e1_x1) + 16'(ram_rdata_b) * 16'(e1_fx_reg));
    assign h1_next = 16'(16'(ram_rdata_a) * 16'(e2_x1) + 16'(ram_rdata_b) * 16'(e2_fx_reg));
    assign v0_next = 24'(e2_y1) * 24'(e2_h0_reg);
    assign v1      = 24'(e3_fy_reg) * 24'(e3_h1_reg);
    assign acc     = e3_v0_reg + v1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= bis_pkg::BK_FIRST;
            pend_reg     <= '0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            e3_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            e1_valid_reg <= issue;
            e2_valid_reg <= e1_valid_reg;
            e3_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        e1_oor_reg <= (cmd_info.kind == bis_pkg::CMD_FLAG);
        e1_fx_reg  <= cmd_info.fx;
        e1_fy_reg  <= cmd_info.fy;
        e2_oor_reg <= e1_oor_reg;
        e2_fx_reg  <= e1_fx_reg;
        e2_fy_reg  <= e1_fy_reg;
        e2_h0_reg  <= h0_next;
        e3_oor_reg <= e2_oor_reg;
        e3_fy_reg  <= e2_fy_reg;
        e3_h1_reg  <= h1_next;
        e3_v0_reg  <= v0_next;
    end

    assign res_valid        = e3_valid_reg;
    assign res.out_of_range = e3_oor_reg;
    assign res.pixel_out    = e3_oor_reg ? 8'd0 : acc[23:16];

endmodule

// ===== src/bilinear_image_sampler_top.sv =====
`timescale 1ns / 1ps

// Bilinear grayscale sampler over an on-chip frame store of MAX_WIDTH x MAX_HEIGHT
// 8-bit pixels. Words with tuser 0 load one source pixel and give no result;
// words with tuser 1 ask for one output pixel and give one result word, with
// tuser set and data 0 when the position lies outside the output or source image.
// A load writes the store once; a sample reads it twice, in BK_FIRST and then
// BK_SECOND, as its four neighbours are read two at a time through the store's
// two read ports; loads stream at one per cycle while no sample or flag is queued
// ahead of them. The store holds no defined value until written. The user must
// write sizes and scales only while idle; the block itself does not enforce it.
module bilinear_image_sampler_top #(
    parameter int unsigned MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bis_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [bis_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // src_row, src_col, src_pixel, out_row, out_col
    input  logic [39:0]                     s_axis_tdata,
    // mode
    input  logic [0:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // pixel_out
    output logic [7:0]                      m_axis_tdata,
    // out_of_range
    output logic [0:0]                      m_axis_tuser
);

    localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned INFO_W = $bits(bis_pkg::cmd_info_t);
    localparam int unsigned CMD_W  = INFO_W + 4 * AW;
    localparam int unsigned RES_W  = $bits(bis_pkg::res_t);

    bis_pkg::cfg_t cfg_reg;

    logic                   fe_valid;
    logic                   fe_ready;
    bis_pkg::cmd_info_t     fe_info;
    logic [3:0][AW-1:0]     fe_addr;

    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [CMD_W-1:0]       cmd_word;
    bis_pkg::cmd_info_t     cmd_info;
    logic [3:0][AW-1:0]     cmd_addr;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [7:0]             ram_wdata;
    logic [AW-1:0]          ram_raddr_a;
    logic [AW-1:0]          ram_raddr_b;
    logic [7:0]             ram_rdata_a;
    logic [7:0]             ram_rdata_b;

    logic                   res_valid;
    logic                   res_ready;
    bis_pkg::res_t          res;
    bis_pkg::res_t          res_head;
    logic [RES_W-1:0]       res_word;
    logic                   res_taken;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_x    <= bis_pkg::RST_SCALE;
            cfg_reg.scale_y    <= bis_pkg::RST_SCALE;
            cfg_reg.in_width   <= bis_pkg::RST_DIM;
            cfg_reg.in_height  <= bis_pkg::RST_DIM;
            cfg_reg.out_width  <= bis_pkg::RST_DIM;
            cfg_reg.out_height <= bis_pkg::RST_DIM;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                bis_pkg::REG_SCALE_X:    cfg_reg.scale_x    <= cfg_wdata;
                bis_pkg::REG_SCALE_Y:    cfg_reg.scale_y    <= cfg_wdata;
                bis_pkg::REG_IN_WIDTH:   cfg_reg.in_width   <= cfg_wdata[8:0];
                bis_pkg::REG_IN_HEIGHT:  cfg_reg.in_height  <= cfg_wdata[8:0];
                bis_pkg::REG_OUT_WIDTH:  cfg_reg.out_width  <= cfg_wdata[8:0];
                bis_pkg::REG_OUT_HEIGHT: cfg_reg.out_height <= cfg_wdata[8:0];
                default:                 cfg_reg            <= cfg_reg;
            endcase
        end
    end

    bis_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (s_axis_tuser[0]),
        .src_row    (s_axis_tdata[7:0]),
        .src_col    (s_axis_tdata[15:8]),
        .src_pixel  (s_axis_tdata[23:16]),
        .out_row    (s_axis_tdata[31:24]),
        .out_col    (s_axis_tdata[39:32]),
        .cmd_valid  (fe_valid),
        .cmd_ready  (fe_ready),
        .cmd_info   (fe_info),
        .cmd_addr   (fe_addr)
    );

    bis_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (bis_pkg::CMDQ_DEPTH)
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_data   ({fe_addr, fe_info}),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_data  (cmd_word)
    );

    assign cmd_info = bis_pkg::cmd_info_t'(cmd_word[INFO_W-1:0]);
    assign cmd_addr = cmd_word[CMD_W-1:INFO_W];

    bis_back #(
        .AW (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_info    (cmd_info),
        .cmd_addr    (cmd_addr),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .res_valid   (res_valid),
        .res         (res),
        .res_taken   (res_taken)
    );

    bis_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // never overflows: the back end only issues against free slots
    bis_fifo #(
        .WIDTH (RES_W),
        .DEPTH (bis_pkg::RES_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (res_word)
    );

    assign res_head        = bis_pkg::res_t'(res_word);
    assign res_taken       = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata    = res_head.pixel_out;
    assign m_axis_tuser[0] = res_head.out_of_range;

endmodule
